// File: sv/bsb_pkg.sv
// ----------------------------------------------------------------------------
// bsb_pkg: shared types and constants of the B-spline basis row unit
// Q7.24 fixed point, transfer types for item and result, chain stage data.
// ----------------------------------------------------------------------------
`default_nettype none

package bsb_pkg;

    localparam int MAX_KNOTS_DEF = 32;
    localparam int MAX_ORDER_DEF = 7;

    localparam int Q_FRAC = 24;
    localparam int KN_W   = 34;   // padded knot width, covers the order range
    localparam int PV_W   = 32;   // basis value width
    localparam int DIV_W  = 64;   // divider operand width
    localparam int IV_W   = 29;   // knot interval width
    localparam int RND_W  = 40;   // rounded product width
    localparam int COL_W  = 6;

    localparam logic signed [KN_W-1:0] Q_ONE_KN = KN_W'(1) <<< Q_FRAC;
    localparam logic signed [PV_W-1:0] Q_ONE_PV = PV_W'(1) <<< Q_FRAC;
    localparam logic [DIV_W-1:0]       TEN_Q    = DIV_W'(10) << Q_FRAC;
    localparam logic signed [DIV_W-1:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [DIV_W-1:0] S32_MIN = -64'sd2147483648;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SPLINE_ORDER = 2'd1;
    localparam logic [1:0] CFG_KNOT_COUNT   = 2'd2;

    // item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic               action;
        logic [4:0]         knot_slot;
        logic signed [31:0] knot_value;
        logic [11:0]        sample_row;
    } bsb_item_t;

    typedef struct packed {
        logic [COL_W-1:0]   basis_column;
        logic signed [31:0] basis_value;
        logic               last_of_row;
    } bsb_result_t;

    typedef struct packed {
        logic signed [KN_W-1:0] kn;
        logic signed [PV_W-1:0] pv;
    } bsb_stage_t;

    function automatic logic signed [PV_W-1:0] sat32(input logic signed [DIV_W-1:0] v);
        logic signed [PV_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = PV_W'(S32_MAX);
        end
        else if (v < S32_MIN)
        begin
            r = PV_W'(S32_MIN);
        end
        else
        begin
            r = PV_W'(v);
        end
        return r;
    endfunction

    // divide by one in Q.24, round to nearest, ties away from zero
    function automatic logic signed [RND_W-1:0] round_q24(input logic signed [DIV_W-1:0] v);
        logic [DIV_W-1:0] mag;
        logic [RND_W-1:0] m;
        mag = v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
        m   = RND_W'((mag + (DIV_W'(1) << (Q_FRAC - 1))) >> Q_FRAC);
        return v[DIV_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

// File: sv/bsb_ram.sv
// ----------------------------------------------------------------------------
// bsb_ram: generic single write port RAM
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/bsb_div.sv
// ----------------------------------------------------------------------------
// bsb_div: iterative signed divider, rounded to nearest
// Restoring radix-2 division, one quotient bit a cycle, ties away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_div
    import bsb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DIV_W-1:0] num,
    input  wire logic signed [DIV_W-1:0] den,
    output logic                         done,
    output logic signed [DIV_W-1:0]      quo
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] rem_reg;
    logic             neg_reg;

    logic [DIV_W-1:0] an;
    logic [DIV_W-1:0] ad;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             ge;

    always_comb
    begin
        an      = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
        ad      = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
        rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // (2|n| + |d|) / (2|d|) gives the rounded magnitude
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= (an << 1) + ad;
            dvs_reg <= ad << 1;
            rem_reg <= '0;
            neg_reg <= num[DIV_W-1] ^ den[DIV_W-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

endmodule

`default_nettype wire

// File: sv/bsb_cell.sv
// ----------------------------------------------------------------------------
// bsb_cell: one stage of the knot and basis value ring
// Holds one padded knot and its basis value, takes its neighbour's on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_cell
    import bsb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire bsb_stage_t nb,
    output bsb_stage_t      q
);

    bsb_stage_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= nb;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: sv/bspline_basis_row_unit.sv
// ----------------------------------------------------------------------------
// bspline_basis_row_unit: Cox-de Boor B-spline basis row, Q7.24
// Knot store, padded knot ring of cells, shared iterative divider.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data (ready always high)
//  item     | item_valid / item_stall  | item   (bsb_item_t)
//  result   | result_valid/result_stall| result (bsb_result_t)
//
//  A knot load is written to the store as the item is taken. An evaluation
//  divides out t and the knot interval, scans the knots for scaling, fills
//  the MAX_KNOTS+2*MAX_ORDER+2 ring stages (dividing each stored knot when
//  scaled), sets the indicators, runs order rounds of the recursion, emits.
//  Reset sets config defaults and control state; knot store and ring are kept.
//  Result stalls hold the ring; the last result may wait while a new item enters.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_basis_row_unit
    import bsb_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire bsb_item_t   item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output bsb_result_t      result
);

    localparam int PAD = MAX_KNOTS + 2 * MAX_ORDER + 2;
    localparam int PCW = $clog2(PAD + 1);
    localparam int CIW = $clog2(PAD);
    localparam int AW  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int KNW = $clog2(MAX_KNOTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_T_GO, ST_T_WAIT, ST_IV_GO, ST_IV_WAIT, ST_SCAN, ST_SCAN_CHK,
        ST_FILL, ST_FILL_KNOT, ST_FILL_DIV, ST_IND, ST_LV, ST_TERM_GO,
        ST_TERM_WAIT, ST_TERM_MUL, ST_TERM_RND, ST_ROT, ST_EMIT
    } state_t;

    state_t state_reg;

    logic [12:0]    n_cfg_reg;
    logic [2:0]     ord_cfg_reg;
    logic [5:0]     nk_cfg_reg;

    logic [11:0]    nm1_reg;
    logic [11:0]    r_reg;
    logic [OW-1:0]  ord_reg;
    logic [KNW-1:0] nk_reg;
    logic [PCW-1:0] b1_reg;
    logic [PCW-1:0] b2_reg;
    logic [PCW-1:0] total_reg;
    logic [PCW-1:0] count_reg;
    logic [PCW-1:0] p_reg;
    logic [PCW-1:0] idx_reg;
    logic [PCW-1:0] c_reg;
    logic [OW-1:0]  j_reg;
    logic           phase_reg;
    logic           scale_reg;

    logic signed [KN_W-1:0]  t_reg;
    logic [IV_W-1:0]         iv_reg;
    logic signed [PV_W-1:0]  q_reg;
    logic signed [DIV_W-1:0] prod_reg;
    logic signed [RND_W-1:0] acc_reg;
    logic signed [PV_W-1:0]  sum_reg;

    logic        res_valid_reg;
    bsb_result_t res_reg;

    // clamped configuration values for the row being accepted
    logic [11:0]    nm1_c;
    logic [11:0]    r_c;
    logic [OW-1:0]  ord_c;
    logic [KNW-1:0] nk_c;

    // ring
    bsb_stage_t stage_q [PAD];
    bsb_stage_t tail;
    logic       shift;

    // divider and store
    logic                    div_start;
    logic signed [DIV_W-1:0] div_num;
    logic signed [DIV_W-1:0] div_den;
    logic                    div_done;
    logic signed [DIV_W-1:0] div_q;
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [31:0]             ram_rdata;

    // datapath
    logic [OW-1:0]           lead_ofs;
    logic [OW-1:0]           trail_ofs;
    logic [IV_W+OW-1:0]      lead_mag;
    logic [IV_W+OW-1:0]      trail_mag;
    logic signed [KN_W-1:0]  fill_kn;
    logic                    fill_user;
    logic                    ind;
    logic signed [KN_W-1:0]  kn_lo;
    logic signed [KN_W-1:0]  kn_k1;
    logic signed [KN_W-1:0]  kn_mid;
    logic signed [KN_W-1:0]  kn_hi;
    logic signed [KN_W:0]    term_num;
    logic signed [KN_W:0]    term_den;
    logic signed [PV_W-1:0]  term_pv;
    logic signed [RND_W-1:0] rnd;
    logic                    live;
    logic                    emit_load;
    logic                    item_take;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        if (n_cfg_reg < 13'd2)
        begin
            nm1_c = 12'd1;
        end
        else if (n_cfg_reg > 13'd4096)
        begin
            nm1_c = 12'd4095;
        end
        else
        begin
            nm1_c = 12'(n_cfg_reg - 13'd1);
        end
        r_c   = (item.sample_row > nm1_c) ? nm1_c : item.sample_row;
        ord_c = (32'(ord_cfg_reg) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(ord_cfg_reg);
        nk_c  = (32'(nk_cfg_reg) > MAX_KNOTS) ? KNW'(MAX_KNOTS) : KNW'(nk_cfg_reg);
    end

    bsb_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KNOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.knot_slot)),
        .wdata (item.knot_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we = item_take && (item.action == ACT_LOAD)
                    && (32'(item.knot_slot) < MAX_KNOTS);

    bsb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    genvar g;
    generate
        for (g = 0; g < PAD; g++)
        begin : g_ring
            if (g == PAD - 1)
            begin : g_tail
                bsb_cell u_cell (.clk(clk), .shift(shift), .nb(tail), .q(stage_q[g]));
            end
            else
            begin : g_body
                bsb_cell u_cell (.clk(clk), .shift(shift), .nb(stage_q[g+1]), .q(stage_q[g]));
            end
        end
    endgenerate

    // padded knot for fill position p
    always_comb
    begin
        lead_ofs  = OW'(ord_reg - OW'(p_reg));
        trail_ofs = OW'(p_reg - b2_reg);
        lead_mag  = iv_reg * lead_ofs;
        trail_mag = iv_reg * trail_ofs;
        fill_user = (p_reg >= b1_reg) && (p_reg < b2_reg);
        if (p_reg < b1_reg)
        begin
            fill_kn = -KN_W'(lead_mag);
        end
        else if ((p_reg >= b2_reg) && (p_reg < total_reg))
        begin
            fill_kn = Q_ONE_KN + KN_W'(trail_mag);
        end
        else
        begin
            fill_kn = '0;
        end
        ram_raddr = (state_reg == ST_SCAN) ? AW'(idx_reg) : AW'(p_reg - b1_reg);
    end

    // recursion terms on the head of the ring
    always_comb
    begin
        kn_lo    = stage_q[0].kn;
        kn_k1    = stage_q[1].kn;
        kn_mid   = stage_q[CIW'(j_reg)].kn;
        kn_hi    = stage_q[CIW'(j_reg) + CIW'(1)].kn;
        ind      = (kn_lo <= t_reg) && (t_reg < kn_k1);
        term_num = phase_reg ? (kn_hi - t_reg) : (t_reg - kn_lo);
        term_den = phase_reg ? (kn_hi - kn_k1) : (kn_mid - kn_lo);
        term_pv  = phase_reg ? stage_q[1].pv : stage_q[0].pv;
        rnd      = round_q24(prod_reg);
        live     = (({1'b0, idx_reg} + (PCW+1)'(j_reg) + (PCW+1)'(1)) < {1'b0, total_reg});
        emit_load = (state_reg == ST_EMIT) && (!res_valid_reg || !result_stall);
    end

    always_comb
    begin
        shift     = 1'b0;
        tail      = stage_q[0];
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_T_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(r_reg) << Q_FRAC;
                div_den   = DIV_W'(nm1_reg);
            end
            ST_IV_GO:
            begin
                div_start = 1'b1;
                div_num   = TEN_Q;
                div_den   = DIV_W'(nm1_reg);
            end
            ST_FILL:
            begin
                if ((p_reg != PCW'(PAD)) && !fill_user)
                begin
                    shift   = 1'b1;
                    tail.kn = fill_kn;
                    tail.pv = '0;
                end
            end
            ST_FILL_KNOT:
            begin
                if (scale_reg)
                begin
                    div_start = 1'b1;
                    div_num   = DIV_W'($signed(ram_rdata));
                    div_den   = DIV_W'(nm1_reg) + DIV_W'(2);
                end
                else
                begin
                    shift   = 1'b1;
                    tail.kn = KN_W'($signed(ram_rdata));
                    tail.pv = '0;
                end
            end
            ST_FILL_DIV:
            begin
                if (div_done)
                begin
                    shift   = 1'b1;
                    tail.kn = KN_W'(div_q);
                    tail.pv = '0;
                end
            end
            ST_IND:
            begin
                shift   = 1'b1;
                tail.pv = ind ? Q_ONE_PV : '0;
            end
            ST_TERM_GO:
            begin
                if (term_den != '0)
                begin
                    div_start = 1'b1;
                    div_num   = DIV_W'(term_num) <<< Q_FRAC;
                    div_den   = DIV_W'(term_den);
                end
            end
            ST_ROT:
            begin
                shift   = 1'b1;
                tail.pv = sum_reg;
            end
            ST_EMIT:
            begin
                shift = emit_load;
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_cfg_reg     <= 13'd2;
            ord_cfg_reg   <= 3'd3;
            nk_cfg_reg    <= 6'd0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            nm1_reg       <= '0;
            r_reg         <= '0;
            ord_reg       <= '0;
            nk_reg        <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            p_reg         <= '0;
            idx_reg       <= '0;
            c_reg         <= '0;
            j_reg         <= '0;
            phase_reg     <= 1'b0;
            scale_reg     <= 1'b0;
            t_reg         <= '0;
            iv_reg        <= '0;
            q_reg         <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT: n_cfg_reg   <= cfg_data;
                    CFG_SPLINE_ORDER: ord_cfg_reg <= cfg_data[2:0];
                    CFG_KNOT_COUNT:   nk_cfg_reg  <= cfg_data[5:0];
                    default:          n_cfg_reg   <= n_cfg_reg;
                endcase
            end

            // result register: drop on transfer, refill while emitting
            if (emit_load)
            begin
                res_valid_reg        <= 1'b1;
                res_reg.basis_column <= COL_W'(c_reg);
                res_reg.basis_value  <= stage_q[0].pv;
                res_reg.last_of_row  <= (c_reg == count_reg - PCW'(1));
            end
            else if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_take && (item.action == ACT_EVAL))
                    begin
                        nm1_reg   <= nm1_c;
                        r_reg     <= r_c;
                        ord_reg   <= ord_c;
                        nk_reg    <= nk_c;
                        b1_reg    <= PCW'(ord_c) + PCW'(1);
                        b2_reg    <= PCW'(ord_c) + PCW'(1) + PCW'(nk_c);
                        total_reg <= PCW'(nk_c) + PCW'(ord_c) + PCW'(ord_c) + PCW'(2);
                        count_reg <= PCW'(nk_c) + PCW'(ord_c) + PCW'(1);
                        state_reg <= ST_T_GO;
                    end
                end
                ST_T_GO:
                begin
                    state_reg <= ST_T_WAIT;
                end
                ST_T_WAIT:
                begin
                    if (div_done)
                    begin
                        t_reg     <= KN_W'(div_q);
                        state_reg <= ST_IV_GO;
                    end
                end
                ST_IV_GO:
                begin
                    state_reg <= ST_IV_WAIT;
                end
                ST_IV_WAIT:
                begin
                    if (div_done)
                    begin
                        iv_reg    <= IV_W'(div_q);
                        scale_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == PCW'(nk_reg))
                    begin
                        p_reg     <= '0;
                        state_reg <= ST_FILL;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK:
                begin
                    if (($signed(ram_rdata) <= 0) || ($signed(ram_rdata) >= $signed(Q_ONE_PV)))
                    begin
                        scale_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + PCW'(1);
                    state_reg <= ST_SCAN;
                end
                ST_FILL:
                begin
                    if (p_reg == PCW'(PAD))
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_IND;
                    end
                    else if (fill_user)
                    begin
                        state_reg <= ST_FILL_KNOT;
                    end
                    else
                    begin
                        p_reg <= p_reg + PCW'(1);
                    end
                end
                ST_FILL_KNOT:
                begin
                    if (scale_reg)
                    begin
                        state_reg <= ST_FILL_DIV;
                    end
                    else
                    begin
                        p_reg     <= p_reg + PCW'(1);
                        state_reg <= ST_FILL;
                    end
                end
                ST_FILL_DIV:
                begin
                    if (div_done)
                    begin
                        p_reg     <= p_reg + PCW'(1);
                        state_reg <= ST_FILL;
                    end
                end
                ST_IND:
                begin
                    if (idx_reg == PCW'(PAD - 1))
                    begin
                        idx_reg   <= '0;
                        j_reg     <= OW'(1);
                        c_reg     <= '0;
                        state_reg <= (ord_reg == '0) ? ST_EMIT : ST_LV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + PCW'(1);
                    end
                end
                ST_LV:
                begin
                    if (live)
                    begin
                        phase_reg <= 1'b0;
                        state_reg <= ST_TERM_GO;
                    end
                    else
                    begin
                        sum_reg   <= stage_q[0].pv;
                        state_reg <= ST_ROT;
                    end
                end
                ST_TERM_GO:
                begin
                    if (term_den == '0)
                    begin
                        prod_reg  <= '0;
                        state_reg <= ST_TERM_RND;
                    end
                    else
                    begin
                        state_reg <= ST_TERM_WAIT;
                    end
                end
                ST_TERM_WAIT:
                begin
                    if (div_done)
                    begin
                        q_reg     <= sat32(div_q);
                        state_reg <= ST_TERM_MUL;
                    end
                end
                ST_TERM_MUL:
                begin
                    prod_reg  <= q_reg * term_pv;
                    state_reg <= ST_TERM_RND;
                end
                ST_TERM_RND:
                begin
                    if (!phase_reg)
                    begin
                        acc_reg   <= rnd;
                        phase_reg <= 1'b1;
                        state_reg <= ST_TERM_GO;
                    end
                    else
                    begin
                        sum_reg   <= sat32(DIV_W'(acc_reg) + DIV_W'(rnd));
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    if (idx_reg == PCW'(PAD - 1))
                    begin
                        idx_reg <= '0;
                        if (j_reg == ord_reg)
                        begin
                            c_reg     <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            j_reg     <= j_reg + OW'(1);
                            state_reg <= ST_LV;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + PCW'(1);
                        state_reg <= ST_LV;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        c_reg <= c_reg + PCW'(1);
                        if (c_reg == count_reg - PCW'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a non-final column only appears while the row is being emitted
    a_mid_row_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_row |-> state_reg == ST_EMIT)
        else $error("non-final column outside emit");

    // the divider only finishes where a quotient is awaited
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_T_WAIT || state_reg == ST_IV_WAIT
                      || state_reg == ST_FILL_DIV || state_reg == ST_TERM_WAIT))
        else $error("divider result with no consumer");

    // an accepted evaluation starts the row sequence
    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item.action == ACT_EVAL |=> state_reg == ST_T_GO)
        else $error("evaluation did not start");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the B-spline basis row unit
// Loads knots, sweeps register settings and sample rows, and checks every
// basis value against a fixed-point Cox-de Boor predictor, under random idling.
// ----------------------------------------------------------------------------

module testbench;

    import bsb_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int ORDER_LIMIT = 7;
    localparam int PAD_LEN     = STORE_DEPTH + 2 * ORDER_LIMIT + 2;
    localparam longint ONE_Q   = 64'sd1 << 24;
    localparam int DRAIN_GAP   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SAMPLE_COUNT;
    logic [12:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    bsb_item_t   item_bus = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    bsb_result_t result_bus;

    // predictor state
    logic signed [31:0] knot_mem [STORE_DEPTH];
    logic [12:0]        reg_samples;
    logic [2:0]         reg_order;
    logic [5:0]         reg_knots;

    bsb_result_t basis_due[$];
    int          error_count = 0;
    int          send_pct = 0;
    int          recv_pct = 0;
    int          hold_cycles = 0;

    bspline_basis_row_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus)
    );

    always #2 clk = ~clk;

    initial
    begin
        #400_000_000;
        $display("bspline_basis_row_unit regression: fail");
        $finish;
    end

    // rounded division, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint unsigned mn;
        longint unsigned md;
        longint unsigned q;
        mn = (num < 0) ? longint'(-num) : num;
        md = (den < 0) ? longint'(-den) : den;
        q  = (2 * mn + md) / (2 * md);
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint blend_term(input longint num, input longint den,
                                          input longint prev);
        longint ratio;
        if (den == 0)
        begin
            return 0;
        end
        ratio = clip32(round_div(num * ONE_Q, den));
        return round_div(ratio * prev, ONE_Q);
    endfunction

    // work out the basis row for one evaluation and queue its results
    task automatic predict_row(input logic [11:0] row_in);
        longint      kn [PAD_LEN];
        longint      pv [PAD_LEN];
        longint      n;
        longint      t;
        longint      step;
        longint      den;
        longint      r;
        longint      a;
        longint      b;
        int          ord;
        int          nk;
        int          total;
        int          cols;
        bit          scale;
        bsb_result_t res;
        n = reg_samples;
        if (n < 2) n = 2;
        if (n > 4096) n = 4096;
        ord = reg_order;
        nk  = (reg_knots > STORE_DEPTH) ? STORE_DEPTH : reg_knots;
        r   = row_in;
        if (r > n - 1) r = n - 1;
        t    = round_div(r * ONE_Q, n - 1);
        step = round_div(10 * ONE_Q, n - 1);
        scale = 1'b0;
        for (int i = 0; i < nk; i++)
        begin
            if (knot_mem[i] <= 0 || longint'(knot_mem[i]) >= ONE_Q) scale = 1'b1;
        end
        den   = scale ? n + 1 : 1;
        total = nk + 2 * ord + 2;
        for (int i = 0; i <= ord; i++) kn[i] = -step * (ord - i);
        for (int i = 0; i < nk; i++) kn[ord + 1 + i] = round_div(knot_mem[i], den);
        for (int i = 0; i <= ord; i++) kn[ord + 1 + nk + i] = ONE_Q + i * step;
        for (int i = 0; i < total - 1; i++)
        begin
            pv[i] = (kn[i] <= t && t < kn[i + 1]) ? ONE_Q : 0;
        end
        for (int j = 1; j <= ord; j++)
        begin
            for (int i = 0; i + j + 1 < total; i++)
            begin
                a = blend_term(t - kn[i], kn[i + j] - kn[i], pv[i]);
                b = blend_term(kn[i + j + 1] - t, kn[i + j + 1] - kn[i + 1], pv[i + 1]);
                pv[i] = clip32(a + b);
            end
        end
        cols = nk + ord + 1;
        for (int c = 0; c < cols; c++)
        begin
            res.basis_column = COL_W'(c);
            res.basis_value  = pv[c][31:0];
            res.last_of_row  = (c == cols - 1);
            basis_due.push_back(res);
        end
    endtask

    // offer one item; hold it until the transfer, then update the predictor
    task automatic send_item(input bsb_item_t it);
        logic stalled;
        if ($urandom_range(99) < send_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_pct);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        do
        begin
            @(negedge clk);
            stalled = item_stall;
            @(posedge clk);
        end
        while (stalled);
        if (it.action == ACT_LOAD)
        begin
            if (it.knot_slot < STORE_DEPTH) knot_mem[it.knot_slot] = it.knot_value;
        end
        else
        begin
            predict_row(it.sample_row);
        end
    endtask

    task automatic load_knot(input int slot, input logic signed [31:0] value);
        bsb_item_t it;
        it = '0;
        it.action     = ACT_LOAD;
        it.knot_slot  = 5'(slot);
        it.knot_value = value;
        it.sample_row = 12'($urandom);
        send_item(it);
    endtask

    task automatic eval_row(input logic [11:0] row);
        bsb_item_t it;
        it = '0;
        it.action     = ACT_EVAL;
        it.knot_slot  = 5'($urandom);
        it.knot_value = $urandom;
        it.sample_row = row;
        send_item(it);
    endtask

    // wait for the block to go quiet before a register write
    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (basis_due.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_COUNT: reg_samples = value;
            CFG_SPLINE_ORDER: reg_order   = value[2:0];
            CFG_KNOT_COUNT:   reg_knots   = value[5:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(input int n, input int ord, input int k);
        wait_quiet();
        write_reg(CFG_SAMPLE_COUNT, 13'(n));
        write_reg(CFG_SPLINE_ORDER, 13'(ord));
        write_reg(CFG_KNOT_COUNT, 13'(k));
    endtask

    // sorted knots strictly inside (0,1) in the first k slots
    task automatic load_sorted(input int k);
        int span;
        int v;
        span = (1 << 24) / (k + 1);
        v = 0;
        for (int i = 0; i < k; i++)
        begin
            v = v + 1 + $urandom_range(span - 1);
            load_knot(i, v);
        end
    endtask

    // count down the long receiver hold
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0) hold_cycles = hold_cycles - 1;
        end
    end

    // result side: sample at the falling edge, act at the rising edge
    initial
    begin
        logic        took;
        bsb_result_t got;
        bsb_result_t want;
        forever
        begin
            @(negedge clk);
            took = rst_n && result_valid && !result_stall;
            got  = result_bus;
            @(posedge clk);
            if (took)
            begin
                if (basis_due.size() == 0)
                begin
                    $display("%0t: unexpected result col=%0d val=%0d last=%0b", $realtime,
                             got.basis_column, got.basis_value, got.last_of_row);
                    error_count++;
                end
                else
                begin
                    want = basis_due.pop_front();
                    if (got.basis_column !== want.basis_column)
                    begin
                        $display("%0t: basis_column expected %0d actual %0d", $realtime,
                                 want.basis_column, got.basis_column);
                        error_count++;
                    end
                    if (got.basis_value !== want.basis_value)
                    begin
                        $display("%0t: basis_value col %0d expected %0d actual %0d",
                                 $realtime, want.basis_column, want.basis_value,
                                 got.basis_value);
                        error_count++;
                    end
                    if (got.last_of_row !== want.last_of_row)
                    begin
                        $display("%0t: last_of_row col %0d expected %0b actual %0b",
                                 $realtime, want.basis_column, want.last_of_row,
                                 got.last_of_row);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    task automatic test_reset_defaults();
        // fill the store so no row ever reads an unwritten entry
        for (int i = 0; i < STORE_DEPTH; i++) load_knot(i, 32'sd1 << 23);
        eval_row(12'd0);
        eval_row(12'd1);
        eval_row(12'hFFF);
    endtask

    task automatic test_knot_extremes();
        set_regs(5, 3, 6);
        load_knot(0, 32'sh8000_0000);
        load_knot(1, 32'sh7FFF_FFFF);
        load_knot(2, 32'sd0);
        load_knot(3, 32'sd1 << 24);
        load_knot(4, -32'sd1);
        load_knot(31, 32'sh00FF_FFFF);
        eval_row(12'd0);
        eval_row(12'd2);
        eval_row(12'd4);
        load_sorted(6);
        eval_row(12'd3);
    endtask

    task automatic test_zero_denominator();
        set_regs(3, 3, 4);
        // repeated knots make the recursion divide by zero
        for (int i = 0; i < 4; i++) load_knot(i, 32'sd1 << 23);
        eval_row(12'd1);
        eval_row(12'd0);
    endtask

    task automatic test_register_limits();
        set_regs(0, 0, 0);
        eval_row(12'd0);
        eval_row(12'd7);
        set_regs(8191, 7, 63);
        load_sorted(STORE_DEPTH);
        eval_row(12'd2048);
        set_regs(4096, 7, 32);
        eval_row(12'd4095);
        set_regs(2, 7, 1);
        eval_row(12'd1);
    endtask

    task automatic test_random_rows();
        int n;
        int k;
        int cnt;
        for (int seg = 0; seg < 12; seg++)
        begin
            case (seg / 4)
                0: begin send_pct = 14; recv_pct = 70; end
                1: begin send_pct = 70; recv_pct = 14; end
                default: begin send_pct = 0; recv_pct = 0; end
            endcase
            case ($urandom_range(5))
                0: n = 2;
                1: n = 4096;
                2: n = $urandom_range(8191);
                default: n = $urandom_range(2, 40);
            endcase
            k = ($urandom_range(9) == 0) ? $urandom_range(7, 63) : $urandom_range(4);
            set_regs(n, $urandom_range(7), k);
            if ($urandom_range(1)) load_sorted((k > STORE_DEPTH) ? STORE_DEPTH : k);
            cnt = $urandom_range(8, 14);
            for (int i = 0; i < cnt; i++)
            begin
                if ($urandom_range(9) < 3)
                begin
                    load_knot($urandom_range(31), ($urandom_range(1)) ?
                              $urandom : $urandom_range(1, (1 << 24) - 1));
                end
                else if ($urandom_range(4) == 0)
                begin
                    eval_row(12'($urandom));
                end
                else
                begin
                    eval_row(12'($urandom_range((n < 2) ? 1 : ((n > 4096) ? 4095 : n - 1))));
                end
            end
        end
    endtask

    task automatic test_receiver_hold();
        send_pct = 0;
        recv_pct = 0;
        set_regs(2, 0, 0);
        hold_cycles = 4000;
        for (int i = 0; i < 12; i++) eval_row(12'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        reg_samples = 13'd2;
        reg_order   = 3'd3;
        reg_knots   = 6'd0;
        repeat (2) @(posedge clk);
        send_pct = 14;
        recv_pct = 70;
        test_reset_defaults();
        test_knot_extremes();
        test_zero_denominator();
        test_register_limits();
        test_receiver_hold();
        test_random_rows();
        item_valid <= 1'b0;
        while (basis_due.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        if (error_count == 0)
        begin
            $display("bspline_basis_row_unit regression: pass");
        end
        else
        begin
            $display("bspline_basis_row_unit regression: fail");
        end
        $finish;
    end

endmodule
